### sv/fkach_pkg.sv
// Package for the fixed-key AES column hash: widths, S-box table, GF helpers.
// No dependencies.
`default_nettype none
package fkach_pkg;
  localparam int WordW = 64;
  localparam int IdxW = 32;
  localparam int BlkW = 128;
  localparam int Rounds = 10;
  localparam logic [63:0] GoldenMul = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] KeyLowReset = 64'h48534148504E4B49;
  localparam logic [63:0] KeyHighReset = 64'h000000003159454B;
  localparam logic CFG_KEY_LOW = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [BlkW-1:0] blk_t;

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t rcon(input int unsigned r);
    byte_t v;
    v = 8'h01;
    for (int unsigned i = 1; i < r; i++) v = xtime(v);
    return v;
  endfunction
endpackage
`default_nettype wire

### sv/fkach_round.sv
// One AES-128 round plus the matching key expansion step.
// Depends on fkach_pkg.
`default_nettype none
module fkach_round (
  input  wire fkach_pkg::blk_t  state_i,
  input  wire fkach_pkg::blk_t  rk_i,
  input  wire fkach_pkg::byte_t rcon_i,
  input  wire                   last_i,
  output fkach_pkg::blk_t       state_o,
  output fkach_pkg::blk_t       rk_o
);
  import fkach_pkg::*;

  byte_t s [16];
  byte_t sh [16];
  byte_t mx [16];
  byte_t t [4];
  logic [31:0] w0, w1, w2, w3;
  blk_t rk_new;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = SBOX[state_i[8*i +: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) sh[c*4+i] = s[((c+i) % 4)*4 + i];
    for (int c = 0; c < 4; c++) begin
      mx[c*4]   = xtime(sh[c*4]) ^ xtime(sh[c*4+1]) ^ sh[c*4+1] ^ sh[c*4+2] ^ sh[c*4+3];
      mx[c*4+1] = sh[c*4] ^ xtime(sh[c*4+1]) ^ xtime(sh[c*4+2]) ^ sh[c*4+2] ^ sh[c*4+3];
      mx[c*4+2] = sh[c*4] ^ sh[c*4+1] ^ xtime(sh[c*4+2]) ^ xtime(sh[c*4+3]) ^ sh[c*4+3];
      mx[c*4+3] = xtime(sh[c*4]) ^ sh[c*4] ^ sh[c*4+1] ^ sh[c*4+2] ^ xtime(sh[c*4+3]);
    end
    t[0] = SBOX[rk_i[111:104]] ^ rcon_i;
    t[1] = SBOX[rk_i[119:112]];
    t[2] = SBOX[rk_i[127:120]];
    t[3] = SBOX[rk_i[103:96]];
    w0 = rk_i[31:0] ^ {t[3], t[2], t[1], t[0]};
    w1 = rk_i[63:32] ^ w0;
    w2 = rk_i[95:64] ^ w1;
    w3 = rk_i[127:96] ^ w2;
    rk_new = {w3, w2, w1, w0};
    for (int i = 0; i < 16; i++)
      state_o[8*i +: 8] = (last_i ? sh[i] : mx[i]) ^ rk_new[8*i +: 8];
    rk_o = rk_new;
  end
endmodule
`default_nettype wire

### sv/fixed_key_aes_column_hash.sv
// Fixed-key AES-128 column hash, top level. Uses fkach_pkg and fkach_round.
// Pipeline: tweak multiply stage, whitening stage, then ten round stages;
// the key schedule travels with each item.
// Throughput: one item per cycle; the whole pipeline holds on output stall.
// Reset (synchronous, rst_n low) clears the valid bits and loads the key.
`default_nettype none
module fixed_key_aes_column_hash (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [159:0] in_tdata,   // column_low, column_high, tweak_index
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata,  // hash_value
  input  wire          cfg_we,
  input  wire          cfg_addr,
  input  wire  [63:0]  cfg_wdata
);
  import fkach_pkg::*;

  localparam int Last = Rounds + 1;

  logic [WordW-1:0] key_low_r, key_high_r;
  logic             v_r [0:Last];
  logic [WordW-1:0] lo_r [0:Last];
  logic [WordW-1:0] hi0_r;
  logic [IdxW-1:0]  idx0_r;
  logic [WordW-1:0] plo0_r;
  logic [31:0]      phi0_r;
  blk_t             key0_r;
  blk_t             st_r [1:Last];
  blk_t             rk_r [1:Rounds];
  blk_t             st_nxt [2:Last];
  blk_t             rk_nxt [2:Last];
  logic [WordW-1:0] mix;
  logic             adv;

  assign adv = !v_r[Last] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = v_r[Last];
  assign out_tdata = st_r[Last][63:0] ^ lo_r[Last];
  assign mix = plo0_r + {phi0_r, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= KeyLowReset;
      key_high_r <= KeyHighReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_LOW:  key_low_r <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Last; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k <= Last; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r[0] <= in_tdata[63:0];
      hi0_r <= in_tdata[127:64];
      idx0_r <= in_tdata[159:128];
      plo0_r <= {32'b0, in_tdata[159:128]} * {32'b0, GoldenMul[31:0]};
      phi0_r <= 32'(in_tdata[159:128] * GoldenMul[63:32]);
      key0_r <= {key_high_r, key_low_r};
      for (int k = 1; k <= Last; k++) lo_r[k] <= lo_r[k-1];
      st_r[1] <= {hi0_r ^ mix, lo_r[0] ^ {32'b0, idx0_r}} ^ key0_r;
      rk_r[1] <= key0_r;
      for (int k = 2; k <= Last; k++) st_r[k] <= st_nxt[k];
      for (int k = 2; k <= Rounds; k++) rk_r[k] <= rk_nxt[k];
    end
  end

  genvar g;
  generate
    for (g = 2; g <= Last; g++) begin : g_rnd
      fkach_round u_round (
        .state_i(st_r[g-1]),
        .rk_i   (rk_r[g-1]),
        .rcon_i (rcon(g-1)),
        .last_i (g == Last),
        .state_o(st_nxt[g]),
        .rk_o   (rk_nxt[g])
      );
    end
  endgenerate
endmodule
`default_nettype wire
